@@ hdl/pps_pkg.sv @@
// Package for the preemptive priority scheduler: sizes, word types, event codes, states.
`default_nettype none
package pps_pkg;

  // Table sizing
  localparam int MAX_JOBS  = 16;
  localparam int SLOT_W    = $clog2(MAX_JOBS);
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int TIME_BITS = 16;
  localparam int USED_W    = 16;
  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Event codes
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_ENDED     = 3'd1,
    EV_SUSPENDED = 3'd2,
    EV_STARTED   = 3'd3,
    EV_RESUMED   = 3'd4
  } kind_t;

  // Tick sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN_RD,
    ST_RUN_CHK,
    ST_SCAN,
    ST_EV0,
    ST_EV1
  } state_t;

  // Input word
  typedef struct packed {
    logic        operation;
    logic [15:0] job_arrival;
    logic [7:0]  job_priority;
    logic [15:0] job_burst;
    logic [15:0] job_number;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] event_time;
    logic [3:0]  event_slot;
    logic [15:0] event_number;
    logic [7:0]  event_priority;
    logic        all_done;
    logic        last_event;
  } out_word_t;

  // One job table entry
  typedef struct packed {
    logic [15:0] arrival;
    logic [7:0]  prio;
    logic [15:0] burst;
    logic [15:0] number;
  } job_t;

  // Job memory access controls
  typedef struct packed {
    logic              job_we;
    logic              used_we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

endpackage
`default_nettype wire

@@ hdl/preemptive_priority_scheduler.sv @@
// Top level: job loading, tick sequencer with memory scan, and event output.
// Load word: taken at once while idle, busy stays low, loads may come back to back.
// Tick word: busy from the tick through the scan and the event words; the scan
//   reads one table slot per cycle through the job memory's single read port.
// Events appear on out_word with out_strobe one cycle apiece, first one after the scan
//   ends; a second event follows in the very next cycle.
// Reset (rst_n low, synchronous) empties the table, stops the running job, zeroes time.
`default_nettype none
module preemptive_priority_scheduler (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire pps_pkg::in_word_t  in_word,
  output logic                    out_strobe,
  output pps_pkg::out_word_t      out_word
);

  localparam int NJ = pps_pkg::MAX_JOBS;
  localparam int SW = pps_pkg::SLOT_W;
  localparam int CW = pps_pkg::CNT_W;
  localparam int TW = pps_pkg::TIME_BITS;
  localparam int UW = pps_pkg::USED_W;

  // Control state
  pps_pkg::state_t     state_r, state_nxt;
  logic [TW-1:0]       tick_r, tick_nxt;
  logic [CW-1:0]       loaded_cnt_r, loaded_cnt_nxt;
  logic [CW-1:0]       ended_cnt_r, ended_cnt_nxt;
  logic [NJ-1:0]       started_r, started_nxt;
  logic [NJ-1:0]       ended_r, ended_nxt;
  logic [SW-1:0]       running_slot_r, running_slot_nxt;
  logic                running_valid_r, running_valid_nxt;
  logic [CW-1:0]       scan_addr_r, scan_addr_nxt;
  logic                pv_r, pv_nxt;
  logic                out_strobe_r, out_strobe_nxt;

  // Per-tick working registers
  logic [SW-1:0]       pidx_r, pidx_nxt;
  logic                ended_v_r, ended_v_nxt;
  logic                prev_valid_r, prev_valid_nxt;
  logic [15:0]         run_num_r, run_num_nxt;
  logic [7:0]          run_pri_r, run_pri_nxt;
  logic                cand_valid_r, cand_valid_nxt;
  logic                cand_held_r, cand_held_nxt;
  logic [SW-1:0]       cand_r, cand_nxt;
  logic [7:0]          cand_pri_r, cand_pri_nxt;
  logic [15:0]         cand_arr_r, cand_arr_nxt;
  logic [15:0]         cand_num_r, cand_num_nxt;
  logic [UW-1:0]       cand_used_r, cand_used_nxt;
  pps_pkg::kind_t      ev1_kind_r, ev1_kind_nxt;
  pps_pkg::out_word_t  out_word_r, out_word_nxt;

  // Memory interface
  pps_pkg::mem_req_t   mem_req;
  pps_pkg::job_t       wr_job;
  logic [UW-1:0]       wr_used;
  pps_pkg::job_t       rd_job;
  logic [UW-1:0]       rd_used;

  logic                accept;
  logic                end_hit;
  logic                elig;
  logic                take;
  logic                switched;
  logic                has2;
  logic                done;
  pps_pkg::kind_t      cand_kind;

  pps_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .wr_job  (wr_job),
    .wr_used (wr_used),
    .rd_job  (rd_job),
    .rd_used (rd_used)
  );

  assign busy       = (state_r != pps_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Next state and datapath
  always_comb begin
    state_nxt         = state_r;
    tick_nxt          = tick_r;
    loaded_cnt_nxt    = loaded_cnt_r;
    ended_cnt_nxt     = ended_cnt_r;
    started_nxt       = started_r;
    ended_nxt         = ended_r;
    running_slot_nxt  = running_slot_r;
    running_valid_nxt = running_valid_r;
    scan_addr_nxt     = scan_addr_r;
    pv_nxt            = pv_r;
    out_strobe_nxt    = 1'b0;
    pidx_nxt          = pidx_r;
    ended_v_nxt       = ended_v_r;
    prev_valid_nxt    = prev_valid_r;
    run_num_nxt       = run_num_r;
    run_pri_nxt       = run_pri_r;
    cand_valid_nxt    = cand_valid_r;
    cand_held_nxt     = cand_held_r;
    cand_nxt          = cand_r;
    cand_pri_nxt      = cand_pri_r;
    cand_arr_nxt      = cand_arr_r;
    cand_num_nxt      = cand_num_r;
    cand_used_nxt     = cand_used_r;
    ev1_kind_nxt      = ev1_kind_r;
    out_word_nxt      = out_word_r;

    mem_req           = '0;
    mem_req.raddr     = running_slot_r;
    wr_job.arrival    = in_word.job_arrival;
    wr_job.prio       = in_word.job_priority;
    wr_job.burst      = in_word.job_burst;
    wr_job.number     = in_word.job_number;
    wr_used           = '0;

    end_hit   = 1'b0;
    elig      = 1'b0;
    take      = 1'b0;
    switched  = cand_valid_r && (!prev_valid_r || (running_slot_r != cand_r));
    cand_kind = started_r[cand_r] ? pps_pkg::EV_RESUMED : pps_pkg::EV_STARTED;
    has2      = 1'b0;
    done      = (ended_cnt_r == loaded_cnt_r);

    case (state_r)
      pps_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_word.operation == pps_pkg::OP_TICK) begin
            tick_nxt  = tick_r + TW'(1);
            state_nxt = pps_pkg::ST_RUN_RD;
          end else if (loaded_cnt_r < CW'(NJ)) begin
            // load into next free slot, used time and flags cleared
            mem_req.job_we  = 1'b1;
            mem_req.used_we = 1'b1;
            mem_req.waddr   = loaded_cnt_r[SW-1:0];
            started_nxt[loaded_cnt_r[SW-1:0]] = 1'b0;
            ended_nxt[loaded_cnt_r[SW-1:0]]   = 1'b0;
            loaded_cnt_nxt  = loaded_cnt_r + CW'(1);
          end
        end
      end

      pps_pkg::ST_RUN_RD: begin
        mem_req.raddr = running_slot_r;
        state_nxt     = pps_pkg::ST_RUN_CHK;
      end

      pps_pkg::ST_RUN_CHK: begin
        // running job ends once its used time reaches its burst
        end_hit        = running_valid_r && (rd_used >= rd_job.burst);
        ended_v_nxt    = end_hit;
        prev_valid_nxt = running_valid_r && !end_hit;
        run_num_nxt    = rd_job.number;
        run_pri_nxt    = rd_job.prio;
        if (end_hit) begin
          ended_nxt[running_slot_r] = 1'b1;
          ended_cnt_nxt             = ended_cnt_r + CW'(1);
        end
        // candidate seeded with the job still running
        cand_valid_nxt = running_valid_r && !end_hit;
        cand_held_nxt  = running_valid_r && !end_hit;
        cand_nxt       = running_slot_r;
        cand_pri_nxt   = rd_job.prio;
        cand_arr_nxt   = rd_job.arrival;
        cand_num_nxt   = rd_job.number;
        cand_used_nxt  = rd_used;
        // first scan read
        mem_req.raddr  = '0;
        pidx_nxt       = '0;
        pv_nxt         = (loaded_cnt_r != '0);
        scan_addr_nxt  = (loaded_cnt_r != '0) ? CW'(1) : '0;
        state_nxt      = pps_pkg::ST_SCAN;
      end

      pps_pkg::ST_SCAN: begin
        // compare the slot whose data just came back
        if (pv_r) begin
          elig = !ended_r[pidx_r] && !(32'(rd_job.arrival) > 32'(tick_r));
          if (elig) begin
            if (!cand_valid_r) begin
              take = 1'b1;
            end else if (rd_job.prio < cand_pri_r) begin
              take = 1'b1;
            end else if (!cand_held_r && (rd_job.prio == cand_pri_r) &&
                         ((rd_job.arrival < cand_arr_r) ||
                          ((rd_job.arrival == cand_arr_r) && (pidx_r < cand_r)))) begin
              take = 1'b1;
            end
          end
          if (take) begin
            cand_nxt       = pidx_r;
            cand_valid_nxt = 1'b1;
            cand_held_nxt  = 1'b0;
            cand_pri_nxt   = rd_job.prio;
            cand_arr_nxt   = rd_job.arrival;
            cand_num_nxt   = rd_job.number;
            cand_used_nxt  = rd_used;
          end
        end
        // issue the next slot read
        if (scan_addr_r < loaded_cnt_r) begin
          mem_req.raddr = scan_addr_r[SW-1:0];
          pidx_nxt      = scan_addr_r[SW-1:0];
          pv_nxt        = 1'b1;
          scan_addr_nxt = scan_addr_r + CW'(1);
        end else begin
          pv_nxt = 1'b0;
        end
        if (!pv_r) begin
          state_nxt = pps_pkg::ST_EV0;
        end
      end

      pps_pkg::ST_EV0: begin
        out_strobe_nxt            = 1'b1;
        out_word_nxt.event_time   = 16'(tick_r);
        out_word_nxt.all_done     = done;
        if (ended_v_r) begin
          out_word_nxt.event_kind     = pps_pkg::EV_ENDED;
          out_word_nxt.event_slot     = 4'(running_slot_r);
          out_word_nxt.event_number   = run_num_r;
          out_word_nxt.event_priority = run_pri_r;
          has2                        = switched;
        end else if (switched && prev_valid_r) begin
          out_word_nxt.event_kind     = pps_pkg::EV_SUSPENDED;
          out_word_nxt.event_slot     = 4'(running_slot_r);
          out_word_nxt.event_number   = run_num_r;
          out_word_nxt.event_priority = run_pri_r;
          has2                        = 1'b1;
        end else if (switched) begin
          out_word_nxt.event_kind     = cand_kind;
          out_word_nxt.event_slot     = 4'(cand_r);
          out_word_nxt.event_number   = cand_num_r;
          out_word_nxt.event_priority = cand_pri_r;
        end else begin
          out_word_nxt.event_kind     = pps_pkg::EV_NONE;
          out_word_nxt.event_slot     = '0;
          out_word_nxt.event_number   = '0;
          out_word_nxt.event_priority = '0;
        end
        out_word_nxt.last_event = !has2;
        ev1_kind_nxt            = cand_kind;
        // commit the new running job and bump its used time
        running_valid_nxt = cand_valid_r;
        if (cand_valid_r) begin
          running_slot_nxt = cand_r;
          mem_req.used_we  = 1'b1;
          mem_req.waddr    = cand_r;
          wr_used          = (cand_used_r == pps_pkg::USED_MAX) ? cand_used_r
                                                                : cand_used_r + UW'(1);
        end
        if (switched) begin
          started_nxt[cand_r] = 1'b1;
        end
        state_nxt = has2 ? pps_pkg::ST_EV1 : pps_pkg::ST_IDLE;
      end

      pps_pkg::ST_EV1: begin
        // second word is always the start or resume of the new job
        out_strobe_nxt              = 1'b1;
        out_word_nxt.event_kind     = ev1_kind_r;
        out_word_nxt.event_time     = 16'(tick_r);
        out_word_nxt.event_slot     = 4'(cand_r);
        out_word_nxt.event_number   = cand_num_r;
        out_word_nxt.event_priority = cand_pri_r;
        out_word_nxt.all_done       = done;
        out_word_nxt.last_event     = 1'b1;
        state_nxt                   = pps_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= pps_pkg::ST_IDLE;
      tick_r          <= '0;
      loaded_cnt_r    <= '0;
      ended_cnt_r     <= '0;
      started_r       <= '0;
      ended_r         <= '0;
      running_slot_r  <= '0;
      running_valid_r <= 1'b0;
      scan_addr_r     <= '0;
      pv_r            <= 1'b0;
      out_strobe_r    <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      tick_r          <= tick_nxt;
      loaded_cnt_r    <= loaded_cnt_nxt;
      ended_cnt_r     <= ended_cnt_nxt;
      started_r       <= started_nxt;
      ended_r         <= ended_nxt;
      running_slot_r  <= running_slot_nxt;
      running_valid_r <= running_valid_nxt;
      scan_addr_r     <= scan_addr_nxt;
      pv_r            <= pv_nxt;
      out_strobe_r    <= out_strobe_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    ended_v_r    <= ended_v_nxt;
    prev_valid_r <= prev_valid_nxt;
    run_num_r    <= run_num_nxt;
    run_pri_r    <= run_pri_nxt;
    cand_valid_r <= cand_valid_nxt;
    cand_held_r  <= cand_held_nxt;
    cand_r       <= cand_nxt;
    cand_pri_r   <= cand_pri_nxt;
    cand_arr_r   <= cand_arr_nxt;
    cand_num_r   <= cand_num_nxt;
    cand_used_r  <= cand_used_nxt;
    ev1_kind_r   <= ev1_kind_nxt;
    out_word_r   <= out_word_nxt;
  end

  // Checks
  a_strobe_from_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == pps_pkg::ST_EV0 || state_r == pps_pkg::ST_EV1))
    else $error("result word without an event state");

  a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_word.last_event |=> out_strobe && out_word.last_event)
    else $error("first of two event words not followed by the last one");

  a_ended_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ended_cnt_r <= loaded_cnt_r)
    else $error("more jobs ended than loaded");

  a_running_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    running_valid_r |-> (CW'(running_slot_r) < loaded_cnt_r))
    else $error("running slot outside the loaded table");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_word.operation == pps_pkg::OP_TICK) |=> busy)
    else $error("tick accepted without entering the sequencer");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_word.operation == pps_pkg::OP_LOAD) |=> !busy && !out_strobe)
    else $error("load word started the sequencer");

endmodule
`default_nettype wire

@@ hdl/pps_mem.sv @@
// Job table and used-time memories, one write and one registered read port each.
`default_nettype none
module pps_mem (
  input  wire logic                          clk,
  input  wire pps_pkg::mem_req_t             req,
  input  wire pps_pkg::job_t                 wr_job,
  input  wire logic [pps_pkg::USED_W-1:0]    wr_used,
  output pps_pkg::job_t                      rd_job,
  output logic [pps_pkg::USED_W-1:0]         rd_used
);

  pps_pkg::job_t                   job_mem  [pps_pkg::MAX_JOBS];
  logic [pps_pkg::USED_W-1:0]      used_mem [pps_pkg::MAX_JOBS];

  // Job entries: written on load only
  always_ff @(posedge clk) begin
    if (req.job_we) begin
      job_mem[req.waddr] <= wr_job;
    end
    rd_job <= job_mem[req.raddr];
  end

  // Used time: cleared on load, bumped at the end of a tick
  always_ff @(posedge clk) begin
    if (req.used_we) begin
      used_mem[req.waddr] <= wr_used;
    end
    rd_used <= used_mem[req.raddr];
  end

endmodule
`default_nettype wire

@@ test/preemptive_priority_scheduler_tb.sv @@
// Testbench for the preemptive priority scheduler: random load/tick words vs. a predictor.
module preemptive_priority_scheduler_tb;

  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int          RANDOM_WORDS = 1100;
  localparam int          DRAIN_CYCLES = 40;

  // A word waiting to be sent, with the idle cycles that go before it
  typedef struct {
    pps_pkg::in_word_t word;
    int unsigned       gap;
  } queued_word_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  pps_pkg::in_word_t  in_word = '0;
  logic               out_strobe;
  pps_pkg::out_word_t out_word;

  queued_word_t       pending_words[$];
  pps_pkg::out_word_t due_events[$];
  int unsigned        hold_off = 0;
  int unsigned        cycle_count = 0;
  int                 mismatches = 0;

  // Scheduler state as the predictor sees it
  logic [15:0]                slot_arrival [pps_pkg::MAX_JOBS];
  logic [7:0]                 slot_prio    [pps_pkg::MAX_JOBS];
  logic [15:0]                slot_burst   [pps_pkg::MAX_JOBS];
  logic [15:0]                slot_number  [pps_pkg::MAX_JOBS];
  logic [pps_pkg::USED_W-1:0] slot_used    [pps_pkg::MAX_JOBS];
  bit                         slot_started [pps_pkg::MAX_JOBS];
  bit                         slot_ended   [pps_pkg::MAX_JOBS];
  int                         jobs_loaded = 0;
  logic [pps_pkg::SLOT_W-1:0] run_slot = '0;
  bit                         run_valid = 1'b0;
  logic [15:0]                now_tick = '0;

  // Stimulus bookkeeping
  int          gen_loaded = 0;
  logic [15:0] gen_now = '0;
  bit          steady_run = 1'b0;

  preemptive_priority_scheduler DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Event word for one job; slot fields stay zero for a none event
  function automatic pps_pkg::out_word_t job_event(pps_pkg::kind_t kind,
                                                   logic [pps_pkg::SLOT_W-1:0] s);
    pps_pkg::out_word_t e;
    e = '0;
    e.event_kind = kind;
    e.event_time = now_tick;
    if (kind != pps_pkg::EV_NONE) begin
      e.event_slot     = s;
      e.event_number   = slot_number[s];
      e.event_priority = slot_prio[s];
    end
    return e;
  endfunction

  // Apply one accepted word to the predicted state, queue the events it causes
  function automatic void schedule_word(pps_pkg::in_word_t w);
    pps_pkg::out_word_t         evs[$];
    logic [pps_pkg::SLOT_W-1:0] pick;
    logic [pps_pkg::SLOT_W-1:0] prev;
    logic [pps_pkg::SLOT_W-1:0] s;
    bit                         pick_ok;
    bit                         pick_held;
    bit                         had_run;
    bit                         finished;
    if (w.operation == pps_pkg::OP_LOAD) begin
      if (jobs_loaded < pps_pkg::MAX_JOBS) begin
        s = pps_pkg::SLOT_W'(jobs_loaded);
        slot_arrival[s] = w.job_arrival;
        slot_prio[s]    = w.job_priority;
        slot_burst[s]   = w.job_burst;
        slot_number[s]  = w.job_number;
        slot_used[s]    = '0;
        slot_started[s] = 1'b0;
        slot_ended[s]   = 1'b0;
        jobs_loaded++;
      end
      return;
    end
    now_tick = now_tick + 16'd1;
    // running job out of burst ends first
    if (run_valid && slot_used[run_slot] >= slot_burst[run_slot]) begin
      slot_ended[run_slot] = 1'b1;
      evs.push_back(job_event(pps_pkg::EV_ENDED, run_slot));
      run_valid = 1'b0;
    end
    had_run   = run_valid;
    prev      = run_slot;
    pick_ok   = run_valid;
    pick_held = run_valid;
    pick      = run_slot;
    // best arrived job; the running one yields only to strictly better priority
    for (int i = 0; i < jobs_loaded; i++) begin
      if (slot_ended[i] || slot_arrival[i] > now_tick) continue;
      if (!pick_ok) begin
        pick      = pps_pkg::SLOT_W'(i);
        pick_ok   = 1'b1;
        pick_held = 1'b0;
      end else if (slot_prio[i] < slot_prio[pick]) begin
        pick      = pps_pkg::SLOT_W'(i);
        pick_held = 1'b0;
      end else if (!pick_held && slot_prio[i] == slot_prio[pick] &&
                   (slot_arrival[i] < slot_arrival[pick] ||
                    (slot_arrival[i] == slot_arrival[pick] && i < pick))) begin
        pick = pps_pkg::SLOT_W'(i);
      end
    end
    if (pick_ok && (!had_run || prev != pick)) begin
      if (had_run) evs.push_back(job_event(pps_pkg::EV_SUSPENDED, prev));
      if (slot_started[pick]) begin
        evs.push_back(job_event(pps_pkg::EV_RESUMED, pick));
      end else begin
        slot_started[pick] = 1'b1;
        evs.push_back(job_event(pps_pkg::EV_STARTED, pick));
      end
    end
    run_valid = pick_ok;
    if (pick_ok) run_slot = pick;
    if (evs.size() == 0) evs.push_back(job_event(pps_pkg::EV_NONE, '0));
    if (run_valid && slot_used[run_slot] != pps_pkg::USED_MAX) slot_used[run_slot]++;
    finished = 1'b1;
    for (int i = 0; i < jobs_loaded; i++)
      if (!slot_ended[i]) finished = 1'b0;
    foreach (evs[k]) begin
      evs[k].all_done   = finished;
      evs[k].last_event = (k == evs.size() - 1);
      due_events.push_back(evs[k]);
    end
  endfunction

  // Queue a word for the driver; gaps come in idle and back-to-back stretches
  function automatic void push_word(pps_pkg::in_word_t w, bit no_gap);
    queued_word_t q;
    if ($urandom_range(0, 29) == 0) steady_run = !steady_run;
    q.word = w;
    q.gap  = (no_gap || steady_run) ? 0 : $urandom_range(0, 12);
    pending_words.push_back(q);
    if (w.operation == pps_pkg::OP_TICK) gen_now = gen_now + 16'd1;
    else if (gen_loaded < pps_pkg::MAX_JOBS) gen_loaded++;
  endfunction

  function automatic pps_pkg::in_word_t load_word(logic [15:0] arr, logic [7:0] prio,
                                                  logic [15:0] burst, logic [15:0] num);
    pps_pkg::in_word_t w;
    w.operation    = pps_pkg::OP_LOAD;
    w.job_arrival  = arr;
    w.job_priority = prio;
    w.job_burst    = burst;
    w.job_number   = num;
    return w;
  endfunction

  // Tick word; the job fields are don't-care and get noise
  function automatic pps_pkg::in_word_t tick_word();
    pps_pkg::in_word_t w;
    w              = load_word(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
    w.operation    = pps_pkg::OP_TICK;
    return w;
  endfunction

  // Driver: presents queued words, holds each until start && !busy
  always @(posedge clk) begin : drive
    queued_word_t nxt;
    if (!rst_n) begin
      start    <= 1'b0;
      hold_off <= 0;
    end else if (start && !busy) begin
      schedule_word(in_word);
      if (pending_words.size() != 0 && pending_words[0].gap == 0) begin
        nxt = pending_words.pop_front();
        in_word <= nxt.word;
      end else begin
        start <= 1'b0;
        if (pending_words.size() != 0) hold_off <= pending_words[0].gap;
      end
    end else if (!start && pending_words.size() != 0) begin
      if (hold_off != 0) begin
        hold_off <= hold_off - 1;
      end else begin
        nxt = pending_words.pop_front();
        in_word <= nxt.word;
        start   <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: every strobed event word against the oldest expectation
  always @(posedge clk) begin : watch
    pps_pkg::out_word_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (due_events.size() == 0) begin
        $error("event word with none expected: %p", out_word);
        mismatches++;
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", want.event_kind, out_word.event_kind);
        check_field("event_time", want.event_time, out_word.event_time);
        check_field("event_slot", want.event_slot, out_word.event_slot);
        check_field("event_number", want.event_number, out_word.event_number);
        check_field("event_priority", want.event_priority, out_word.event_priority);
        check_field("all_done", want.all_done, out_word.all_done);
        check_field("last_event", want.last_event, out_word.last_event);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int          counted;
    logic [15:0] arr;
    logic [7:0]  prio;
    logic [15:0] burst;
    // tick on an empty table: none event, all done
    push_word(tick_word(), 1'b0);
    // job at worst priority, and a zero-burst job that arrives at tick 3
    push_word(load_word(16'd0, 8'd255, 16'd3, 16'hFFFF), 1'b0);
    push_word(load_word(16'd3, 8'd0, 16'd0, 16'd0), 1'b0);
    // start, preempt, zero-burst end, resume
    repeat (4) push_word(tick_word(), 1'b1);
    // equal priorities: earliest arrival, then lowest slot; held job keeps running
    // until a strictly better one arrives
    push_word(load_word(16'd3, 8'd10, 16'd2, 16'($urandom)), 1'b0);
    push_word(load_word(16'd3, 8'd10, 16'd1, 16'($urandom)), 1'b0);
    push_word(load_word(16'd2, 8'd10, 16'd1, 16'($urandom)), 1'b0);
    push_word(load_word(16'd8, 8'd10, 16'd1, 16'($urandom)), 1'b0);
    push_word(load_word(16'd8, 8'd9, 16'd2, 16'($urandom)), 1'b0);
    repeat (14) push_word(tick_word(), 1'b0);

    // random part: sparse job loads into a ticking schedule, excess loads as noise
    counted = 0;
    while (counted < RANDOM_WORDS) begin
      if ($urandom_range(0, (gen_loaded < pps_pkg::MAX_JOBS) ? 49 : 24) == 0) begin
        if ($urandom_range(0, 3) != 0) arr = gen_now + 16'($urandom_range(0, 100));
        else arr = 16'($urandom_range(0, gen_now));
        prio  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        burst = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 30));
        if (gen_loaded < pps_pkg::MAX_JOBS) counted++;
        push_word(load_word(arr, prio, burst, 16'($urandom)), 1'b0);
      end else begin
        push_word(tick_word(), 1'b0);
        counted++;
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all words sent, all events seen, then let the block settle
    while (pending_words.size() != 0 || start || due_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_events.size() != 0) begin
      $error("%0d expected event words never arrived", due_events.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
